// ----- rtl/cee_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_pkg - shared types and constants of the escape expander
// Register indexes, reset values, status codes, parse modes and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cee_pkg;

    localparam int DEF_BRACE_DEPTH = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_ESCAPE_CHAR     = 2'd0;
    localparam logic [1:0] CFG_SUBSTITUTE_CHAR = 2'd1;
    localparam logic [1:0] CFG_DEST_CAPACITY   = 2'd2;

    localparam logic [7:0]  ESCAPE_CHAR_RST     = 8'd92;
    localparam logic [7:0]  SUBSTITUTE_CHAR_RST = 8'd191;
    localparam logic [15:0] DEST_CAPACITY_RST   = 16'hFFFF;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_FULL        = 2'd1,
        STS_BAD_DIGITS  = 2'd2,
        STS_UNSUPPORTED = 2'd3
    } t_sts;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_ESC,
        M_OCT,
        M_OWAIT,
        M_XRUN,
        M_BOCT,
        M_BHEX
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAIN,
        S_FIN,
        S_SUB,
        S_BUF,
        S_BYTE,
        S_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HANDLE,
        OP_PLAIN,
        OP_FIN,
        OP_SUB,
        OP_BUF,
        OP_BYTE,
        OP_DRAIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic fill_clr;
    } t_cmd;

    typedef struct packed {
        logic step_ok;
        logic drain_ok;
        logic h_plain;
        logic h_overrun;
        logic in_end;
        logic fin_put;
        logic fin_brace;
        logic fill_zero;
        logic buf_last;
    } t_stat;

    typedef struct packed {
        logic [7:0]  data;
        logic        bv;
        t_sts        sts;
        logic [15:0] cnt;
    } t_res;

endpackage

// ----- rtl/cee_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cee_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_ctrl - sequencer of the escape expander
// Walks each accepted beat through handle, follow-up put, end-of-string
// finish, brace flush and result hand-off.
// ----------------------------------------------------------------------------
module cee_ctrl import cee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_flush_byte, n_flush_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_flush_byte <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_flush_byte <= n_flush_byte;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_flush_byte   = r_flush_byte;
        o_cmd.op       = OP_NONE;
        o_cmd.fill_clr = 1'b0;
        o_in_stall     = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op     = OP_HANDLE;
                    n_flush_byte = i_stat.h_overrun;
                    priority if (i_stat.h_plain) begin
                        n_state = S_PLAIN;
                    end else if (i_stat.h_overrun) begin
                        n_state = S_SUB;
                    end else if (i_stat.in_end) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_PLAIN: begin
                if (i_stat.step_ok) begin
                    o_cmd.op = OP_PLAIN;
                    n_state  = S_DRAIN;
                end
            end
            S_FIN: begin
                priority if (i_stat.fin_brace) begin
                    n_state = S_SUB;
                end else if (i_stat.fin_put) begin
                    if (i_stat.step_ok) begin
                        o_cmd.op = OP_FIN;
                        n_state  = S_DRAIN;
                    end
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_SUB: begin
                if (i_stat.step_ok) begin
                    o_cmd.op = OP_SUB;
                    if (i_stat.fill_zero) begin
                        o_cmd.fill_clr = 1'b1;
                        n_state        = r_flush_byte ? S_BYTE : S_DRAIN;
                    end else begin
                        n_state = S_BUF;
                    end
                end
            end
            S_BUF: begin
                if (i_stat.step_ok) begin
                    o_cmd.op = OP_BUF;
                    if (i_stat.buf_last) begin
                        o_cmd.fill_clr = 1'b1;
                        n_state        = r_flush_byte ? S_BYTE : S_DRAIN;
                    end
                end
            end
            S_BYTE: begin
                if (i_stat.step_ok) begin
                    o_cmd.op = OP_BYTE;
                    n_state  = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.drain_ok) begin
                    o_cmd.op = OP_DRAIN;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cee_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_dp - datapath of the escape expander
// Config registers, parse state, brace buffer, put/fail logic, one-deep
// hold stage and the output register.
// ----------------------------------------------------------------------------
module cee_dp import cee_pkg::*; #(
    parameter int BRACE_DEPTH = DEF_BRACE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_end_of_string,
    output logic [1:0]  o_status,
    output logic [15:0] o_byte_count
);

    localparam int AW = $clog2(BRACE_DEPTH);
    localparam int FW = $clog2(BRACE_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U_LC   = 8'h75;
    localparam logic [7:0] CH_U_UC   = 8'h55;
    localparam logic [7:0] CH_N_UC   = 8'h4E;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c <= 8'h39) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    // {hit, value} for the fixed letter escapes
    function automatic logic [8:0] letter_code(input logic [7:0] c);
        unique case (c)
            8'h61:   return {1'b1, 8'd7};
            8'h62:   return {1'b1, 8'd8};
            8'h66:   return {1'b1, 8'd12};
            8'h6E:   return {1'b1, 8'd10};
            8'h72:   return {1'b1, 8'd13};
            8'h74:   return {1'b1, 8'd9};
            8'h76:   return {1'b1, 8'd11};
            8'h65:   return {1'b1, 8'd27};
            8'h27, 8'h22, 8'h5C, 8'h3F: return {1'b1, c};
            default: return {1'b0, 8'h00};
        endcase
    endfunction

    // config
    logic [7:0]  r_esc, r_sub;
    logic [15:0] r_cap;

    // parse state
    t_mode       r_mode, n_mode;
    logic [7:0]  r_acc, n_acc;
    logic        r_seen, n_seen;
    logic [FW-1:0] r_fill, n_fill;
    logic        r_bok, n_bok;
    logic [7:0]  r_bval, n_bval;
    logic [15:0] r_count, n_count;
    t_sts        r_err, n_err;
    logic [7:0]  r_byte, n_byte;
    logic        r_end, n_end;
    logic        r_any, n_any;
    logic [FW-1:0] r_idx, n_idx;

    // hold stage and output register
    logic        r_hold_v, n_hold_v;
    t_res        r_hold, n_hold;
    logic        r_out_v, n_out_v;
    t_res        r_out, n_out;
    logic        r_out_eos, n_out_eos;

    // put / fail request
    logic        p_put, p_fail;
    logic [7:0]  p_val;
    t_sts        p_code;
    t_res        res;

    // brace RAM
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic          in_end, out_free, b_oct, b_hex, dig_ok, h_plain, h_overrun;
    logic [3:0]    hv;
    logic [8:0]    lc;
    logic [7:0]    bbase;
    logic [FW-1:0] idx_inc;

    cee_ram #(
        .WIDTH (8),
        .DEPTH (BRACE_DEPTH)
    ) u_brace_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_end   = (i_in_byte == CH_NUL) || i_in_last;
    assign out_free = !r_out_v || !i_out_stall;
    assign b_oct    = is_oct(i_in_byte);
    assign b_hex    = is_hex(i_in_byte);
    assign hv       = hex_val(i_in_byte);
    assign lc       = letter_code(i_in_byte);
    assign dig_ok   = (r_mode == M_BHEX) ? b_hex : b_oct;
    assign bbase    = (r_fill == '0) ? 8'h00 : r_bval;
    assign idx_inc  = r_idx + FW'(1);

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_seen    = r_seen;
        n_fill    = r_fill;
        n_bok     = r_bok;
        n_bval    = r_bval;
        n_count   = r_count;
        n_err     = r_err;
        n_byte    = r_byte;
        n_end     = r_end;
        n_any     = r_any;
        n_idx     = r_idx;
        n_hold_v  = r_hold_v;
        n_hold    = r_hold;
        n_out_v   = r_out_v;
        n_out     = r_out;
        n_out_eos = r_out_eos;
        p_put     = 1'b0;
        p_fail    = 1'b0;
        p_val     = 8'h00;
        p_code    = STS_OK;
        res       = r_hold;
        ram_we    = 1'b0;
        ram_waddr = r_fill[AW-1:0];
        ram_wdata = i_in_byte;
        ram_re    = 1'b0;
        ram_raddr = '0;
        h_plain   = 1'b0;
        h_overrun = 1'b0;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        unique case (i_cmd.op)
            OP_HANDLE: begin
                n_byte = i_in_byte;
                n_end  = in_end;
                n_any  = 1'b0;
                if ((r_err == STS_OK) && (i_in_byte != CH_NUL)) begin
                    unique case (r_mode)
                        M_ESC: begin
                            n_mode = M_NORMAL;
                            priority if (lc[8]) begin
                                p_put = 1'b1;
                                p_val = lc[7:0];
                            end else if (i_in_byte == CH_O) begin
                                n_mode = M_OWAIT;
                            end else if (i_in_byte == CH_X) begin
                                n_mode = M_XRUN;
                                n_seen = 1'b0;
                                n_acc  = 8'h00;
                            end else if ((i_in_byte == CH_U_LC) || (i_in_byte == CH_U_UC) ||
                                         (i_in_byte == CH_N_UC)) begin
                                p_fail = 1'b1;
                                p_code = STS_UNSUPPORTED;
                            end else if (b_oct) begin
                                n_mode = M_OCT;
                                n_acc  = {5'b0, i_in_byte[2:0]};
                            end else if (i_in_byte == r_esc) begin
                                p_put = 1'b1;
                                p_val = i_in_byte;
                            end else begin
                                p_put = 1'b1;
                                p_val = r_sub;
                            end
                        end
                        M_OCT: begin
                            if (b_oct) begin
                                n_acc = {r_acc[4:0], i_in_byte[2:0]};
                            end else begin
                                p_put   = 1'b1;
                                p_val   = r_acc;
                                h_plain = 1'b1;
                            end
                        end
                        M_OWAIT: begin
                            if (i_in_byte == CH_LBRACE) begin
                                n_mode = M_BOCT;
                                n_fill = '0;
                            end else begin
                                p_put   = 1'b1;
                                p_val   = r_sub;
                                h_plain = 1'b1;
                            end
                        end
                        M_XRUN: begin
                            priority if (b_hex) begin
                                n_acc  = {r_acc[3:0], hv};
                                n_seen = 1'b1;
                            end else if ((i_in_byte == CH_LBRACE) && !r_seen) begin
                                n_mode = M_BHEX;
                                n_fill = '0;
                            end else begin
                                p_put   = 1'b1;
                                p_val   = r_seen ? r_acc : r_sub;
                                h_plain = 1'b1;
                            end
                        end
                        M_BOCT, M_BHEX: begin
                            priority if (i_in_byte == CH_RBRACE) begin
                                n_mode = M_NORMAL;
                                n_fill = '0;
                                if ((r_fill == '0) || !r_bok) begin
                                    p_fail = 1'b1;
                                    p_code = STS_BAD_DIGITS;
                                end else begin
                                    p_put = 1'b1;
                                    p_val = r_bval;
                                end
                            end else if (r_fill < FW'(BRACE_DEPTH)) begin
                                // value and digit check run as bytes arrive
                                ram_we = 1'b1;
                                n_fill = r_fill + FW'(1);
                                n_bok  = dig_ok && ((r_fill == '0) || r_bok);
                                n_bval = (r_mode == M_BHEX) ? {bbase[3:0], hv} :
                                                              {bbase[4:0], i_in_byte[2:0]};
                            end else begin
                                n_mode    = M_NORMAL;
                                h_overrun = 1'b1;
                            end
                        end
                        default: begin
                            n_mode = (i_in_byte == r_esc) ? M_ESC : M_NORMAL;
                            p_put  = (i_in_byte != r_esc);
                            p_val  = i_in_byte;
                        end
                    endcase
                end
            end
            OP_PLAIN: begin
                n_mode = (r_byte == r_esc) ? M_ESC : M_NORMAL;
                p_put  = (r_byte != r_esc);
                p_val  = r_byte;
            end
            OP_FIN: begin
                unique case (r_mode)
                    M_OCT: begin
                        p_put = 1'b1;
                        p_val = r_acc;
                    end
                    M_OWAIT: begin
                        p_put = 1'b1;
                        p_val = r_sub;
                    end
                    M_XRUN: begin
                        p_put = 1'b1;
                        p_val = r_seen ? r_acc : r_sub;
                    end
                    default: begin
                        p_put = 1'b0;
                    end
                endcase
            end
            OP_SUB: begin
                p_put     = 1'b1;
                p_val     = r_sub;
                n_idx     = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            OP_BUF: begin
                p_put     = 1'b1;
                p_val     = ram_rdata;
                n_idx     = idx_inc;
                ram_re    = 1'b1;
                ram_raddr = idx_inc[AW-1:0];
            end
            OP_BYTE: begin
                p_put = 1'b1;
                p_val = r_byte;
            end
            OP_DRAIN: begin
                if (r_hold_v) begin
                    n_out_v   = 1'b1;
                    n_out     = r_hold;
                    n_out_eos = r_end;
                    n_hold_v  = 1'b0;
                end else if (r_end && !r_any) begin
                    n_out_v   = 1'b1;
                    n_out     = '{data: 8'h00, bv: 1'b0, sts: r_err, cnt: r_count};
                    n_out_eos = 1'b1;
                end
                if (r_end) begin
                    n_mode  = M_NORMAL;
                    n_acc   = 8'h00;
                    n_seen  = 1'b0;
                    n_fill  = '0;
                    n_count = '0;
                    n_err   = STS_OK;
                end
            end
            default: begin
                n_any = r_any;
            end
        endcase

        if (i_cmd.fill_clr) begin
            n_fill = '0;
        end

        // put / fail: nothing once an error is latched
        if ((r_err == STS_OK) && (p_put || p_fail)) begin
            if (p_fail) begin
                n_err = p_code;
                res   = '{data: 8'h00, bv: 1'b0, sts: p_code, cnt: r_count};
            end else if (r_count >= r_cap) begin
                n_err = STS_FULL;
                res   = '{data: 8'h00, bv: 1'b0, sts: STS_FULL, cnt: r_count};
            end else begin
                n_count = r_count + 16'd1;
                res     = '{data: p_val, bv: 1'b1, sts: STS_OK, cnt: r_count + 16'd1};
            end
            if (r_hold_v) begin
                n_out_v   = 1'b1;
                n_out     = r_hold;
                n_out_eos = 1'b0;
            end
            n_hold_v = 1'b1;
            n_hold   = res;
            n_any    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= ESCAPE_CHAR_RST;
            r_sub <= SUBSTITUTE_CHAR_RST;
            r_cap <= DEST_CAPACITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ESCAPE_CHAR:     r_esc <= i_cfg_data[7:0];
                CFG_SUBSTITUTE_CHAR: r_sub <= i_cfg_data[7:0];
                CFG_DEST_CAPACITY:   r_cap <= i_cfg_data;
                default: begin
                    r_cap <= r_cap;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_NORMAL;
            r_acc    <= 8'h00;
            r_seen   <= 1'b0;
            r_fill   <= '0;
            r_count  <= '0;
            r_err    <= STS_OK;
            r_end    <= 1'b0;
            r_any    <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_seen   <= n_seen;
            r_fill   <= n_fill;
            r_count  <= n_count;
            r_err    <= n_err;
            r_end    <= n_end;
            r_any    <= n_any;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bok     <= n_bok;
        r_bval    <= n_bval;
        r_byte    <= n_byte;
        r_idx     <= n_idx;
        r_hold    <= n_hold;
        r_out     <= n_out;
        r_out_eos <= n_out_eos;
    end

    assign o_stat.step_ok   = !r_hold_v || out_free;
    assign o_stat.drain_ok  = out_free || !(r_hold_v || (r_end && !r_any));
    assign o_stat.h_plain   = h_plain;
    assign o_stat.h_overrun = h_overrun;
    assign o_stat.in_end    = in_end;
    assign o_stat.fin_put   = (r_mode == M_OCT) || (r_mode == M_OWAIT) || (r_mode == M_XRUN);
    assign o_stat.fin_brace = (r_mode == M_BOCT) || (r_mode == M_BHEX);
    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.buf_last  = (idx_inc == r_fill);

    assign o_out_valid     = r_out_v;
    assign o_out_byte      = r_out.data;
    assign o_byte_valid    = r_out.bv;
    assign o_end_of_string = r_out_eos;
    assign o_status        = r_out.sts;
    assign o_byte_count    = r_out.cnt;

endmodule

// ----- rtl/c_escape_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_expander - C string escape expander
// Copies a byte stream and replaces escape sequences by the bytes they name.
// ----------------------------------------------------------------------------
// Bytes of a string come in one beat at a time; a zero byte or a beat with
// i_in_last set ends the string. Escapes (backslash by default) cover the
// letter escapes a b f n r t v e, quote, double quote, backslash, question
// mark, octal and hex runs, and braced o{..} / x{..} forms; a numeric value
// keeps its low byte. Unknown letters yield the substitute byte; u, U and N
// give status 3, bad brace contents status 2, and going past dest_capacity
// status 1. The first error of a string gives one beat with o_byte_valid low
// and further bytes of that string give nothing. Every result beat carries
// the string's running byte count; o_end_of_string marks the last beat of a
// string, and a string end that produces nothing still gives one such beat.
// An ordinary byte is decoded on accept, then handed to the output register;
// a byte that closes a digit run and must itself be copied gets a copy step;
// a string end adds a finish step. Brace contents sit in a RAM of BRACE_DEPTH
// bytes with one write and one read port, needing no clearing after reset;
// flushing an unclosed or overrun brace puts out the substitute byte, then
// each buffered byte, paced by the RAM read port. A full output register
// holds the sequencer while it waits, but the next input beat is taken while
// the last result of the previous one still waits at the output. Configuration
// is to be written by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module c_escape_expander import cee_pkg::*; #(
    parameter int BRACE_DEPTH = DEF_BRACE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_end_of_string,
    output logic [1:0]  o_status,
    output logic [15:0] o_byte_count
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one step per cycle, stepping only when the hold stage
    // can move on
    cee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: parse state, brace RAM, put logic, hold and output stages
    cee_dp #(
        .BRACE_DEPTH (BRACE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status),
        .o_byte_count    (o_byte_count)
    );

endmodule

// ----- bench/tb_c_escape_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_escape_expander - self-checking bench for the C escape expander
// Drives byte strings (directed corner cases, then random well-formed escape
// sequences mixed with noise) through six register settings. A scoreboard
// class predicts every result beat and compares it field by field. Both
// channels idle at random, and the receiver holds off once for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_c_escape_expander;
    import cee_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;   // covers a full brace flush and more
    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 36;
    localparam int HOLD_CYCLES   = 250;

    // one expected or observed result beat
    typedef struct packed {
        logic [7:0]  data;
        logic        bv;
        logic        eos;
        t_sts        sts;
        logic [15:0] cnt;
    } beat_t;

    // one input beat waiting to be sent
    typedef struct {
        logic [7:0] data;
        logic       last;
    } src_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the expander state and registers; every
    // accepted input beat is expanded into the result beats it should cause.
    // ------------------------------------------------------------------------
    class expansion_scoreboard;
        logic [7:0]  esc_char;
        logic [7:0]  sub_char;
        logic [15:0] capacity;

        t_mode       mode;
        logic [7:0]  accum;
        logic        digit_seen;
        logic [7:0]  brace_buf [DEF_BRACE_DEPTH];
        int          brace_fill;
        logic [15:0] produced;
        t_sts        err;

        beat_t       awaited_beats [$];
        beat_t       step_beats [$];
        int          mismatches;

        function new();
            esc_char   = ESCAPE_CHAR_RST;
            sub_char   = SUBSTITUTE_CHAR_RST;
            capacity   = DEST_CAPACITY_RST;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            mode       = M_NORMAL;
            accum      = 8'h00;
            digit_seen = 1'b0;
            brace_fill = 0;
            produced   = 16'h0000;
            err        = STS_OK;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_ESCAPE_CHAR:     esc_char = value[7:0];
                CFG_SUBSTITUTE_CHAR: sub_char = value[7:0];
                CFG_DEST_CAPACITY:   capacity = value;
                default: ;
            endcase
        endfunction

        function int oct_val(logic [7:0] c);
            if (c >= "0" && c <= "7") return c - "0";
            return -1;
        endfunction

        function int hex_val(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function void emit(logic [7:0] b, logic bv, t_sts sts);
            beat_t e;
            e.data = b;
            e.bv   = bv;
            e.eos  = 1'b0;
            e.sts  = sts;
            e.cnt  = produced;
            step_beats.push_back(e);
        endfunction

        // only the first error of a string is reported
        function void raise(t_sts code);
            if (err != STS_OK) return;
            err = code;
            emit(8'h00, 1'b0, code);
        endfunction

        function void put(logic [7:0] b);
            if (err != STS_OK) return;
            if (produced >= capacity) begin
                raise(STS_FULL);
                return;
            end
            produced++;
            emit(b, 1'b1, STS_OK);
        endfunction

        function void flush_brace();
            put(sub_char);
            for (int i = 0; i < brace_fill; i++) put(brace_buf[i]);
            brace_fill = 0;
        endfunction

        function void close_brace(bit hex);
            int v;
            int d;
            v = 0;
            if (brace_fill == 0) begin
                raise(STS_BAD_DIGITS);
                return;
            end
            for (int i = 0; i < brace_fill; i++) begin
                d = hex ? hex_val(brace_buf[i]) : oct_val(brace_buf[i]);
                if (d < 0) begin
                    raise(STS_BAD_DIGITS);
                    brace_fill = 0;
                    return;
                end
                v = (v * (hex ? 16 : 8) + d) & 255;
            end
            brace_fill = 0;
            put(v[7:0]);
        endfunction

        function void copy_text(logic [7:0] b);
            mode = M_NORMAL;
            if (b == esc_char) mode = M_ESC;
            else put(b);
        endfunction

        function void escape_letter(logic [7:0] c);
            mode = M_NORMAL;
            case (c)
                "a": put(8'd7);
                "b": put(8'd8);
                "f": put(8'd12);
                "n": put(8'd10);
                "r": put(8'd13);
                "t": put(8'd9);
                "v": put(8'd11);
                "e": put(8'd27);
                "'", "\"", "\\", "?": put(c);
                "o": mode = M_OWAIT;
                "x": begin
                    mode       = M_XRUN;
                    digit_seen = 1'b0;
                    accum      = 8'h00;
                end
                "u", "U", "N": raise(STS_UNSUPPORTED);
                default: begin
                    if (oct_val(c) >= 0) begin
                        mode  = M_OCT;
                        accum = oct_val(c);
                    end else if (c == esc_char) begin
                        put(c);
                    end else begin
                        put(sub_char);
                    end
                end
            endcase
        endfunction

        function void expand_byte(logic [7:0] b);
            int d;
            case (mode)
                M_ESC: escape_letter(b);
                M_OCT: begin
                    d = oct_val(b);
                    if (d >= 0) begin
                        accum = accum * 8 + d;
                    end else begin
                        put(accum);
                        copy_text(b);
                    end
                end
                M_OWAIT: begin
                    if (b == "{") begin
                        mode       = M_BOCT;
                        brace_fill = 0;
                    end else begin
                        put(sub_char);
                        copy_text(b);
                    end
                end
                M_XRUN: begin
                    d = hex_val(b);
                    if (d >= 0) begin
                        accum      = accum * 16 + d;
                        digit_seen = 1'b1;
                    end else if (b == "{" && !digit_seen) begin
                        mode       = M_BHEX;
                        brace_fill = 0;
                    end else begin
                        put(digit_seen ? accum : sub_char);
                        copy_text(b);
                    end
                end
                M_BOCT, M_BHEX: begin
                    if (b == "}") begin
                        close_brace(mode == M_BHEX);
                        mode = M_NORMAL;
                    end else if (brace_fill < DEF_BRACE_DEPTH) begin
                        brace_buf[brace_fill] = b;
                        brace_fill++;
                    end else begin
                        // overrun: the substitute byte, then the buffered bytes and this one as they are
                        flush_brace();
                        put(b);
                        mode = M_NORMAL;
                    end
                end
                default: copy_text(b);
            endcase
        endfunction

        function void end_string();
            case (mode)
                M_OCT:          put(accum);
                M_OWAIT:        put(sub_char);
                M_XRUN:         put(digit_seen ? accum : sub_char);
                M_BOCT, M_BHEX: flush_brace();
                default: ;
            endcase
            if (step_beats.size() == 0) emit(8'h00, 1'b0, err);
            step_beats[step_beats.size() - 1].eos = 1'b1;
            clear_string();
        endfunction

        // accepted input beat: queue up the result beats it causes
        function void note_byte(logic [7:0] b, logic last);
            step_beats.delete();
            if (err == STS_OK && b != 8'h00) expand_byte(b);
            if (b == 8'h00 || last) end_string();
            foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        // accepted result beat: compare with the oldest expectation
        function void check_beat(beat_t got);
            beat_t e;
            if (awaited_beats.size() == 0) begin
                report($sformatf("unexpected beat: byte=%02h bv=%b eos=%b sts=%0d cnt=%0d",
                                 got.data, got.bv, got.eos, got.sts, got.cnt));
                return;
            end
            e = awaited_beats.pop_front();
            if (got.data !== e.data || got.bv !== e.bv || got.eos !== e.eos ||
                got.sts !== e.sts || got.cnt !== e.cnt) begin
                report($sformatf({"mismatch: exp byte=%02h bv=%b eos=%b sts=%0d cnt=%0d",
                                  " | got byte=%02h bv=%b eos=%b sts=%0d cnt=%0d"},
                                 e.data, e.bv, e.eos, e.sts, e.cnt,
                                 got.data, got.bv, got.eos, got.sts, got.cnt));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hook-up
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_end_of_string;
    logic [1:0]  o_status;
    logic [15:0] o_byte_count;

    c_escape_expander DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status),
        .o_byte_count    (o_byte_count)
    );

    expansion_scoreboard sb;
    src_beat_t           stim_q [$];
    logic [7:0]          cur_esc;      // escape byte the generator builds with
    bit                  idle_in;      // sender gaps on for the current string
    int                  long_hold;    // one-off receiver hold-off request
    int                  items_sent;
    int                  cycle_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result monitor: a beat moves when valid is high and stall low
    always @(posedge i_clk) begin
        beat_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.data = o_out_byte;
            got.bv   = o_byte_valid;
            got.eos  = o_end_of_string;
            got.sts  = t_sts'(o_status);
            got.cnt  = o_byte_count;
            sb.check_beat(got);
        end
    end

    // receiver: a random wait before each beat, in stretches with and
    // without stalling; a pending long hold-off replaces the next wait
    initial begin : receiver
        int wait_cycles;
        int run_left;
        bit stall_on;
        run_left = 0;
        stall_on = 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (run_left == 0) begin
                stall_on = ($urandom_range(0, 3) != 0);
                run_left = $urandom_range(5, 30);
            end
            run_left--;
            wait_cycles = stall_on ? $urandom_range(0, 6) : 0;
            if (long_hold > 0) begin
                wait_cycles = long_hold;
                long_hold   = 0;
            end
            @(negedge i_clk);
            if (wait_cycles > 0) begin
                i_out_stall = 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_reg(idx, value);
    endtask

    // valid is left high after acceptance; the next call either replaces
    // the payload at the following falling edge or drops valid for a gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_in ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        i_in_last  = last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b, last);
        items_sent++;
    endtask

    task automatic play_stimulus();
        src_beat_t s;
        while (stim_q.size() != 0) begin
            s = stim_q.pop_front();
            send_byte(s.data, s.last);
        end
    endtask

    // idle the input, let every expected beat arrive, then allow for work
    // still in flight on beats that cause no result
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.awaited_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic void add_beat(logic [7:0] b, logic last);
        src_beat_t s;
        s.data = b;
        s.last = last;
        stim_q.push_back(s);
    endfunction

    function automatic logic [7:0] any_but_close();
        logic [7:0] b;
        do b = $urandom_range(1, 255); while (b == "}");
        return b;
    endfunction

    // brace contents: mostly digits of the base, now and then a stray byte
    function automatic logic [7:0] brace_byte(bit hex);
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 7) == 0) return any_but_close();
        if (hex) return hex_set[$urandom_range(0, 21)];
        return "0" + $urandom_range(0, 7);
    endfunction

    // corner cases under the reset register values
    function automatic void add_directed();
        add_beat(8'hFF, 1'b1);                   // top byte, one-beat string
        add_beat("A", 1'b0);                     // text then newline escape
        add_beat("\\", 1'b0);
        add_beat("n", 1'b1);
        add_beat("\\", 1'b0);                    // empty hex brace: bad digits
        add_beat("x", 1'b0);
        add_beat("{", 1'b0);
        add_beat("}", 1'b0);
        add_beat(8'h00, 1'b0);                   // end after an error
        add_beat("\\", 1'b0);                    // unsupported escape
        add_beat("u", 1'b1);
        add_beat("\\", 1'b0);                    // hex run ended by text
        add_beat("x", 1'b0);
        add_beat("4", 1'b0);
        add_beat("g", 1'b1);
        add_beat("\\", 1'b0);                    // unclosed octal brace
        add_beat("o", 1'b0);
        add_beat("{", 1'b0);
        add_beat("1", 1'b0);
        add_beat("2", 1'b1);
        add_beat("\\", 1'b1);                    // dangling escape
        add_beat(8'h00, 1'b0);                   // empty string
    endfunction

    function automatic void add_random_string();
        int    n_tokens;
        int    len;
        bit    stop;
        bit    hex;
        string letters;
        string hex_set;
        string nope;
        letters  = "abfnrtve'\"\\?";
        hex_set  = "0123456789abcdefABCDEF";
        nope     = "uUN";
        // noise: raw bytes, zeros and end marks anywhere
        if ($urandom_range(0, 11) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) add_beat($urandom_range(0, 255), $urandom_range(0, 5) == 0);
            stim_q[stim_q.size() - 1].last = 1'b1;
            return;
        end
        n_tokens = $urandom_range(1, 5);
        stop     = 1'b0;
        for (int t = 0; t < n_tokens && !stop; t++) begin
            hex = $urandom_range(0, 1);
            case ($urandom_range(0, 15))
                0, 1, 2, 15: begin
                    len = $urandom_range(1, 4);
                    repeat (len) add_beat($urandom_range(1, 255), 1'b0);
                end
                3: begin
                    add_beat(cur_esc, 1'b0);
                    add_beat(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
                end
                4: begin
                    add_beat(cur_esc, 1'b0);
                    len = $urandom_range(1, 4);
                    repeat (len) add_beat("0" + $urandom_range(0, 7), 1'b0);
                end
                5, 7: begin
                    add_beat(cur_esc, 1'b0);
                    add_beat(hex ? "x" : "o", 1'b0);
                    add_beat("{", 1'b0);
                    len = $urandom_range(0, 4);
                    repeat (len) add_beat(brace_byte(hex), 1'b0);
                    add_beat("}", 1'b0);
                end
                6: begin
                    add_beat(cur_esc, 1'b0);
                    add_beat("x", 1'b0);
                    len = $urandom_range(1, 3);
                    repeat (len) add_beat(hex_set[$urandom_range(0, 21)], 1'b0);
                end
                8: begin
                    add_beat(cur_esc, 1'b0);
                    add_beat(nope[$urandom_range(0, 2)], 1'b0);
                end
                9: begin
                    add_beat(cur_esc, 1'b0);
                    add_beat($urandom_range(1, 255), 1'b0);
                end
                10: begin
                    add_beat(cur_esc, 1'b0);
                    add_beat(cur_esc, 1'b0);
                end
                11: begin
                    // o or x left without digits or brace
                    add_beat(cur_esc, 1'b0);
                    add_beat(hex ? "x" : "o", 1'b0);
                    add_beat($urandom_range(1, 255), 1'b0);
                end
                12: begin
                    // brace overrun, kept rare as it is long
                    if ($urandom_range(0, 2) == 0) begin
                        add_beat(cur_esc, 1'b0);
                        add_beat(hex ? "x" : "o", 1'b0);
                        add_beat("{", 1'b0);
                        repeat (DEF_BRACE_DEPTH + 1) add_beat(any_but_close(), 1'b0);
                    end else begin
                        add_beat($urandom_range(1, 255), 1'b0);
                    end
                end
                13: begin
                    // brace left open at the end of the string
                    add_beat(cur_esc, 1'b0);
                    add_beat(hex ? "x" : "o", 1'b0);
                    add_beat("{", 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) add_beat(brace_byte(hex), 1'b0);
                    stop = 1'b1;
                end
                default: begin
                    add_beat(cur_esc, 1'b0);     // dangling escape
                    stop = 1'b1;
                end
            endcase
        end
        // end by a zero byte or by the end mark on the final beat
        if ($urandom_range(0, 1)) add_beat(8'h00, $urandom_range(0, 1));
        else stim_q[stim_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]  esc_val;
        logic [7:0]  sub_val;
        logic [15:0] cap_val;
        int          phase_start;
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_ESCAPE_CHAR;
        i_cfg_data  = 16'h0000;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_in_last   = 1'b0;
        i_out_stall = 1'b0;
        idle_in     = 1'b1;
        long_hold   = 0;
        items_sent  = 0;
        cycle_count = 0;
        cur_esc     = ESCAPE_CHAR_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin                         // reset values, written back
                    esc_val = ESCAPE_CHAR_RST;
                    sub_val = SUBSTITUTE_CHAR_RST;
                    cap_val = DEST_CAPACITY_RST;
                end
                1: begin                         // top escape, no room at all
                    esc_val = 8'hFF;
                    sub_val = 8'h00;
                    cap_val = 16'd0;
                end
                2: begin                         // escape byte outside the table
                    esc_val = "%";
                    sub_val = 8'hFF;
                    cap_val = 16'd6;
                end
                3: begin                         // zero escape: escapes never start
                    esc_val = 8'h00;
                    sub_val = $urandom_range(0, 255);
                    cap_val = 16'd20;
                end
                4: begin
                    esc_val = $urandom_range(1, 255);
                    sub_val = $urandom_range(0, 255);
                    cap_val = $urandom_range(1, 12);
                end
                default: begin                   // backslash again, under back-pressure
                    esc_val = "\\";
                    sub_val = SUBSTITUTE_CHAR_RST;
                    cap_val = DEST_CAPACITY_RST;
                end
            endcase
            if (ph > 0) settle();
            write_reg(CFG_ESCAPE_CHAR, {8'h00, esc_val});
            write_reg(CFG_SUBSTITUTE_CHAR, {8'h00, sub_val});
            write_reg(CFG_DEST_CAPACITY, cap_val);
            cur_esc = esc_val;

            if (ph == 0) begin
                add_directed();
                play_stimulus();
            end
            // last phase: receiver sits still while the sender keeps offering
            if (ph == N_PHASES - 1) long_hold = HOLD_CYCLES;

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                idle_in = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
                add_random_string();
                play_stimulus();
            end
        end

        settle();
        if (sb.mismatches == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
